FILE: rtl/sliding_window_median_six_channel_assert.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef SLIDING_WINDOW_MEDIAN_SIX_CHANNEL_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_SIX_CHANNEL_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swm assertion failed");

// Check cons in the cycle after ante.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swm assertion failed");

`endif

FILE: rtl/swm_pkg.sv
package swm_pkg;

  localparam int unsigned MAX_WINDOW   = 16;
  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned CHANNELS     = 6;
  localparam int unsigned CFG_W        = 5;

  localparam int unsigned SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CH_W    = $clog2(CHANNELS);
  localparam int unsigned DATA_W  = CHANNELS * SAMPLE_WIDTH;
  localparam int unsigned TDATA_W = ((DATA_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] RESET_WINDOW = CFG_W'(11);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SLOT_W-1:0]              slot_t;
  typedef logic [CNT_W-1:0]               cnt_t;

  typedef struct packed {
    logic  wr_en;
    logic  rot_en;
    slot_t wr_slot;
  } hist_ctrl_t;

  typedef struct packed {
    logic    hit;
    sample_t value;
  } rank_res_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RANK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // (s - d) mod MAX_WINDOW
  function automatic slot_t ring_back(slot_t s, slot_t d);
    if (s >= d) begin
      return slot_t'(s - d);
    end
    return slot_t'(int'(s) + int'(MAX_WINDOW) - int'(d));
  endfunction

  // (s + 1) mod MAX_WINDOW
  function automatic slot_t ring_next(slot_t s);
    if (int'(s) == int'(MAX_WINDOW) - 1) begin
      return '0;
    end
    return slot_t'(s + 1'b1);
  endfunction

endpackage

FILE: rtl/swm_history.sv
module swm_history (
  input  logic                 clk_i,
  input  swm_pkg::hist_ctrl_t  ctrl_i,
  input  swm_pkg::sample_t     sample_i [swm_pkg::CHANNELS],
  output swm_pkg::sample_t     row_o    [swm_pkg::MAX_WINDOW]
);

  swm_pkg::sample_t hist_q [swm_pkg::CHANNELS][swm_pkg::MAX_WINDOW];

  // write one beat into every channel row, or rotate rows so row 0 is the next channel
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      for (int c = 0; c < int'(swm_pkg::CHANNELS); c++) begin
        hist_q[c][ctrl_i.wr_slot] <= sample_i[c];
      end
    end else if (ctrl_i.rot_en) begin
      for (int c = 0; c < int'(swm_pkg::CHANNELS); c++) begin
        hist_q[c] <= hist_q[(c == int'(swm_pkg::CHANNELS) - 1) ? 0 : c + 1];
      end
    end
  end

  assign row_o = hist_q[0];

endmodule

FILE: rtl/swm_rank_unit.sv
module swm_rank_unit (
  input  swm_pkg::sample_t   row_i [swm_pkg::MAX_WINDOW],
  input  swm_pkg::slot_t     slot_i,
  input  swm_pkg::cnt_t      count_i,
  input  swm_pkg::slot_t     cand_k_i,
  input  swm_pkg::cnt_t      target_i,
  output swm_pkg::rank_res_t res_o
);

  swm_pkg::slot_t               cand_pos;
  swm_pkg::sample_t             cand;
  logic [swm_pkg::MAX_WINDOW-1:0] less_vec;
  swm_pkg::cnt_t                rank;

  assign cand_pos = swm_pkg::ring_back(slot_i, cand_k_i);
  assign cand     = row_i[cand_pos];

  // order by value, ties broken by age
  always_comb begin
    swm_pkg::slot_t age;
    less_vec = '0;
    for (int j = 0; j < int'(swm_pkg::MAX_WINDOW); j++) begin
      age = swm_pkg::ring_back(slot_i, swm_pkg::slot_t'(j));
      less_vec[j] = (swm_pkg::cnt_t'(age) < count_i) &&
                    ((row_i[j] < cand) || ((row_i[j] == cand) && (age < cand_k_i)));
    end
  end

  assign rank        = swm_pkg::cnt_t'($countones(less_vec));
  assign res_o.hit   = (rank == target_i);
  assign res_o.value = cand;

endmodule

FILE: rtl/sliding_window_median_six_channel.sv
// Six-channel sliding-window median over pose samples (signed Q16.16).
// Input stream: one beat per sample, s_axis_tdata_i holds the six channels.
// Output stream: one beat per input beat, the median of each channel taken
// at index count/2 of the sorted window (upper median for even counts).
// Config channel: cfg_data_i sets the window length (0 acts as 1, values
// above 16 act as 16); write it only while the block is idle.
// Per item the shared rank unit tests one candidate of one channel per
// cycle against the whole window; each channel stops at its median, and
// after the last channel the result is handed to the output register.
// The input is not ready from an accepted beat until that hand-off, so
// the block takes no new beat before the last one is finished.
// Reset: window length 11, window empty; a new window fills one sample per
// beat. When the receiver stalls, the output register holds its beat, the
// block still accepts and works one further item, then waits with it
// finished until the output register frees.
module sliding_window_median_six_channel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // rot_a, rot_b, rot_c, shift_x, shift_y, shift_z (32 bits each)
  input  logic [swm_pkg::TDATA_W-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // med_rot_a, med_rot_b, med_rot_c, med_shift_x, med_shift_y, med_shift_z
  output logic [swm_pkg::TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_data_i
);

  `include "sliding_window_median_six_channel_assert.svh"

  swm_pkg::state_e              st_q, st_d;
  logic [swm_pkg::CFG_W-1:0]    cfg_q;
  swm_pkg::cnt_t                fill_q, count_q, count_d, len;
  swm_pkg::slot_t               oldest_q, slot_q, cand_q;
  logic [swm_pkg::CH_W-1:0]     ch_q;
  swm_pkg::sample_t             res_q [swm_pkg::CHANNELS];
  logic                         out_valid_q;
  logic [swm_pkg::DATA_W-1:0]   out_data_q, res_flat;
  swm_pkg::sample_t             sample_in [swm_pkg::CHANNELS];
  swm_pkg::sample_t             row [swm_pkg::MAX_WINDOW];
  swm_pkg::hist_ctrl_t          hctrl;
  swm_pkg::rank_res_t           rres;
  logic                         s_acc, out_load, last_ch;

  assign s_axis_tready_o = (st_q == swm_pkg::ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign last_ch         = (ch_q == swm_pkg::CH_W'(swm_pkg::CHANNELS - 1));
  assign out_load        = (st_q == swm_pkg::ST_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    for (int c = 0; c < int'(swm_pkg::CHANNELS); c++) begin
      sample_in[c] = s_axis_tdata_i[c*swm_pkg::SAMPLE_WIDTH +: swm_pkg::SAMPLE_WIDTH];
      res_flat[c*swm_pkg::SAMPLE_WIDTH +: swm_pkg::SAMPLE_WIDTH] = res_q[c];
    end
  end

  // effective window and samples taking part after this beat
  always_comb begin
    if (cfg_q == '0) begin
      len = swm_pkg::cnt_t'(1);
    end else if (32'(cfg_q) > 32'(swm_pkg::MAX_WINDOW)) begin
      len = swm_pkg::cnt_t'(swm_pkg::MAX_WINDOW);
    end else begin
      len = swm_pkg::cnt_t'(cfg_q);
    end
    if (fill_q >= len) begin
      count_d = len;
    end else begin
      count_d = swm_pkg::cnt_t'(fill_q + 1'b1);
    end
  end

  assign hctrl.wr_en   = s_acc;
  assign hctrl.rot_en  = (st_q == swm_pkg::ST_RANK) && rres.hit;
  assign hctrl.wr_slot = oldest_q;

  swm_history u_hist (
    .clk_i    (clk_i),
    .ctrl_i   (hctrl),
    .sample_i (sample_in),
    .row_o    (row)
  );

  swm_rank_unit u_rank (
    .row_i    (row),
    .slot_i   (slot_q),
    .count_i  (count_q),
    .cand_k_i (cand_q),
    .target_i (swm_pkg::cnt_t'(count_q >> 1)),
    .res_o    (rres)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      swm_pkg::ST_IDLE: begin
        if (s_acc) st_d = swm_pkg::ST_RANK;
      end
      swm_pkg::ST_RANK: begin
        if (rres.hit && last_ch) st_d = swm_pkg::ST_DONE;
      end
      swm_pkg::ST_DONE: begin
        if (out_load) st_d = swm_pkg::ST_IDLE;
      end
      default: st_d = swm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= swm_pkg::ST_IDLE;
      cfg_q       <= swm_pkg::RESET_WINDOW;
      fill_q      <= '0;
      oldest_q    <= '0;
      slot_q      <= '0;
      count_q     <= '0;
      cand_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (s_acc) begin
        slot_q   <= oldest_q;
        count_q  <= count_d;
        fill_q   <= count_d;
        oldest_q <= swm_pkg::ring_next(oldest_q);
        cand_q   <= '0;
        ch_q     <= '0;
      end else if (st_q == swm_pkg::ST_RANK) begin
        if (rres.hit) begin
          cand_q <= '0;
          if (!last_ch) ch_q <= swm_pkg::CH_W'(ch_q + 1'b1);
        end else begin
          cand_q <= swm_pkg::slot_t'(cand_q + 1'b1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == swm_pkg::ST_RANK) && rres.hit) begin
      res_q[ch_q] <= rres.value;
    end
    if (out_load) begin
      out_data_q <= res_flat;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = swm_pkg::TDATA_W'(out_data_q);

  `SWM_ASSERT_NOW(a_cand_in_window, st_q == swm_pkg::ST_RANK, swm_pkg::cnt_t'(cand_q) < count_q)
  `SWM_ASSERT_NOW(a_chan_in_range, st_q == swm_pkg::ST_RANK, 32'(ch_q) < 32'(swm_pkg::CHANNELS))
  `SWM_ASSERT_NEXT(a_fill_after_beat, s_acc, (fill_q != '0) && (fill_q == count_q))
  `SWM_ASSERT_NEXT(a_done_loads_out, out_load, m_axis_tvalid_o && s_axis_tready_o)

endmodule

FILE: tb/tb_sliding_window_median_six_channel.sv
module tb_sliding_window_median_six_channel;

  typedef logic [swm_pkg::CHANNELS-1:0][swm_pkg::SAMPLE_WIDTH-1:0] pose_t;

  localparam swm_pkg::sample_t S_MAX = 32'sh7fff_ffff;
  localparam swm_pkg::sample_t S_MIN = 32'sh8000_0000;
  localparam swm_pkg::sample_t S_NEG1 = -32'sd1;
  localparam swm_pkg::sample_t S_ZERO = 32'sd0;
  localparam swm_pkg::sample_t S_ONE = 32'sd1;
  localparam swm_pkg::sample_t Q_ONE = 32'sh0001_0000;
  localparam int unsigned RANDOM_ITEMS = 730;

  class median_scoreboard;
    swm_pkg::sample_t ring [swm_pkg::CHANNELS][swm_pkg::MAX_WINDOW];
    int unsigned fill;
    int unsigned next_slot;
    logic [swm_pkg::CFG_W-1:0] window_len;
    pose_t medians_due [$];
    int unsigned errors;
    string chan_name [swm_pkg::CHANNELS] = '{"rot_a", "rot_b", "rot_c",
                                             "shift_x", "shift_y", "shift_z"};

    function new();
      window_len = swm_pkg::RESET_WINDOW;
      fill = 0;
      next_slot = 0;
      errors = 0;
    endfunction

    function void set_window(logic [swm_pkg::CFG_W-1:0] v);
      window_len = v;
    endfunction

    function void note_pose(pose_t p);
      int unsigned span;
      int unsigned cnt;
      int j;
      swm_pkg::sample_t keys [swm_pkg::MAX_WINDOW];
      swm_pkg::sample_t v;
      pose_t med;
      if (window_len == 0) begin
        span = 1;
      end else if (window_len > swm_pkg::MAX_WINDOW) begin
        span = swm_pkg::MAX_WINDOW;
      end else begin
        span = window_len;
      end
      cnt = (fill >= span) ? span : fill + 1;
      for (int c = 0; c < swm_pkg::CHANNELS; c++) begin
        ring[c][next_slot] = p[c];
        for (int k = 0; k < cnt; k++) begin
          keys[k] = ring[c][(next_slot + swm_pkg::MAX_WINDOW - k) % swm_pkg::MAX_WINDOW];
        end
        for (int k = 1; k < cnt; k++) begin
          v = keys[k];
          j = k;
          while (j > 0 && keys[j-1] > v) begin
            keys[j] = keys[j-1];
            j--;
          end
          keys[j] = v;
        end
        med[c] = keys[cnt/2];
      end
      medians_due = {medians_due, med};
      fill = cnt;
      next_slot = (next_slot + 1) % swm_pkg::MAX_WINDOW;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(pose_t got);
      pose_t want;
      if (medians_due.size() == 0) begin
        report("result beat with no median pending");
        return;
      end
      want = medians_due.pop_front();
      for (int c = 0; c < swm_pkg::CHANNELS; c++) begin
        if (got[c] !== want[c]) begin
          report($sformatf("%s: got %0d, expected %0d", chan_name[c],
                           swm_pkg::sample_t'(got[c]), swm_pkg::sample_t'(want[c])));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [swm_pkg::TDATA_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [swm_pkg::TDATA_W-1:0] m_axis_tdata_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [swm_pkg::CFG_W-1:0] cfg_data_i = '0;

  median_scoreboard sb;
  bit steady = 1'b0;
  int unsigned sent = 0;
  swm_pkg::sample_t corner [6] = '{S_MAX, S_MIN, S_ZERO, S_NEG1, S_ONE, Q_ONE};

  sliding_window_median_six_channel u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_pose(pose_t'(s_axis_tdata_i));
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(pose_t'(m_axis_tdata_o));
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 21);
    end
  end

  task automatic hold_off();
    while (!steady && $urandom_range(0, 99) < 21) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
  endtask

  task automatic send_pose(pose_t p);
    hold_off();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= swm_pkg::TDATA_W'(p);
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
  endtask

  // hold input until every median has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.medians_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_window(logic [swm_pkg::CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_window(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned dir_win [6];
    int unsigned dir_len [6];
    int unsigned phase;
    int unsigned run_len;
    logic [swm_pkg::CFG_W-1:0] w;
    pose_t p;
    dir_win = '{11, 3, 1, 0, 31, 5};
    dir_len = '{4, 4, 2, 2, 3, 4};
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset length first, then shrink while full, zero, oversize and shrink
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        write_window(swm_pkg::CFG_W'(dir_win[ph]));
      end
      for (int i = 0; i < dir_len[ph]; i++) begin
        for (int c = 0; c < swm_pkg::CHANNELS; c++) begin
          p[c] = corner[(sent * (c + 1) + c) % 6];
        end
        send_pose(p);
      end
    end

    phase = 0;
    while (sent < RANDOM_ITEMS + 19) begin
      drain();
      case ($urandom_range(0, 9))
        0: w = 5'd0;
        1: w = 5'd31;
        2: w = 5'd16;
        3: w = swm_pkg::CFG_W'($urandom_range(17, 30));
        default: w = swm_pkg::CFG_W'($urandom_range(1, 16));
      endcase
      write_window(w);
      steady = (phase == 4);
      run_len = steady ? 120 : $urandom_range(4, 40);
      repeat (run_len) begin
        for (int c = 0; c < swm_pkg::CHANNELS; c++) begin
          case ($urandom_range(0, 9))
            0, 1: p[c] = $urandom;
            2, 3, 4: p[c] = 32'($urandom_range(0, 8)) - 32'd4;
            5: p[c] = corner[$urandom_range(0, 5)];
            default: p[c] = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
          endcase
        end
        send_pose(p);
      end
      steady = 1'b0;
      phase++;
    end

    drain();
    repeat (6 * swm_pkg::MAX_WINDOW + 4) @(posedge clk_i);
    if (sb.medians_due.size() != 0) begin
      sb.report($sformatf("%0d medians never arrived", sb.medians_due.size()));
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_history.sv
rtl/swm_rank_unit.sv
rtl/sliding_window_median_six_channel.sv
tb/tb_sliding_window_median_six_channel.sv
